// ===== hdl/saq_pkg.sv =====
`timescale 1ns / 1ps

package saq_pkg;

  // field widths of one transaction
  localparam int RoomW  = 14;
  localparam int TimeW  = 32;
  localparam int EventW = 2;
  localparam int PendW  = 7;
  localparam int FiredW = 32;

  // result kinds carried on out_tuser
  localparam logic [EventW-1:0] EV_REGISTERED = 2'd0;
  localparam logic [EventW-1:0] EV_DROPPED    = 2'd1;
  localparam logic [EventW-1:0] EV_FIRED      = 2'd2;
  localparam logic [EventW-1:0] EV_NONE_DUE   = 2'd3;

  // one queue entry as held in memory
  typedef struct packed {
    logic [TimeW-1:0] due_time;
    logic [RoomW-1:0] room;
  } entry_t;

endpackage

// ===== hdl/sorted_alarm_timer_queue.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload                                         | Accepted when
// in_     | in  | tuser: mode; tdata: room_number, alarm_time     | in_tvalid & in_tready
// out_    | out | tuser: event_res; tdata: woken_room, woken_time,| out_tvalid & out_tready
//         |     |   pending_count, expired_count                  |
//
// One transaction is worked on at a time; in_tready is high only while the sequencer idles.
// Register: every queued entry due later than the new one is moved up one slot by a read
// and a write of the single entry memory; the new entry is then written into the freed
// slot, or behind the tail when it is the latest. A full queue drops the new entry.
// Tick: one memory read of the head, popped when due; an empty queue reports none due.
// Entries sit in a ring buffer, so removing the head only advances a pointer.
// Reset clears the counts and pointers only; the memory needs no clearing pass.
// A stalled out_tready holds the result register; the block then waits to finish the next item.
module sorted_alarm_timer_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [47:0]                in_tdata,   // room_number[13:0], alarm_time[45:14]
  input  logic                       in_tuser,   // mode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [87:0]                out_tdata,  // woken_room[13:0], woken_time[45:14],
                                                 // pending_count[52:46], expired_count[84:53]
  output logic [saq_pkg::EventW-1:0] out_tuser   // event_res
);
  import saq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_TICK_RD  = 3'd3;
  localparam logic [2:0] S_TICK_CMP = 3'd4;
  localparam logic [2:0] S_PUSH     = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [FiredW-1:0] fired_r, fired_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     left_r, left_nxt;

  // latched input item
  logic [RoomW-1:0] room_r, room_nxt;
  logic [TimeW-1:0] time_r, time_nxt;

  // finished result waiting for the output register
  logic [EventW-1:0] res_ev_r, res_ev_nxt;
  entry_t            res_woken_r, res_woken_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [EventW-1:0] out_ev_r, out_ev_nxt;
  entry_t            out_woken_r, out_woken_nxt;
  logic [PendW-1:0]  out_pend_r, out_pend_nxt;
  logic [FiredW-1:0] out_fired_r, out_fired_nxt;

  // entry memory
  entry_t        mem [QUEUE_DEPTH];
  entry_t        mem_rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic [AW-1:0] mem_ra;

  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] pos_prev;
  logic [AW-1:0] head_next;
  entry_t        new_entry;

  // ring arithmetic
  always_comb begin
    tail_sum  = {1'b0, head_r} + (AW+1)'(occ_r);
    tail_idx  = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    pos_prev  = (pos_r == '0) ? LAST_IDX : pos_r - 1'b1;
    head_next = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    new_entry = '{due_time: time_r, room: room_r};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    fired_nxt     = fired_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    room_nxt      = room_r;
    time_nxt      = time_r;
    res_ev_nxt    = res_ev_r;
    res_woken_nxt = res_woken_r;
    out_valid_nxt = out_valid_r;
    out_ev_nxt    = out_ev_r;
    out_woken_nxt = out_woken_r;
    out_pend_nxt  = out_pend_r;
    out_fired_nxt = out_fired_r;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = new_entry;
    mem_ra        = head_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          room_nxt = in_tdata[13:0];
          time_nxt = in_tdata[45:14];
          pos_nxt  = tail_idx;
          left_nxt = occ_r;
          state_nxt = in_tuser ? S_TICK_RD : S_INS_RD;
        end
      end

      // insert: drop on a full queue; place here once no earlier slot is left, else look one slot down
      S_INS_RD: begin
        res_woken_nxt = '0;
        if (occ_r == FULL_CNT) begin
          res_ev_nxt = EV_DROPPED;
          state_nxt  = S_PUSH;
        end else if (left_r == '0) begin
          mem_we     = 1'b1;
          occ_nxt    = occ_r + 1'b1;
          res_ev_nxt = EV_REGISTERED;
          state_nxt  = S_PUSH;
        end else begin
          mem_ra    = pos_prev;
          state_nxt = S_INS_CMP;
        end
      end

      // later entry moves up one slot; an equal or earlier one stays below
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (mem_rd_r.due_time > time_r) begin
          mem_wd    = mem_rd_r;
          pos_nxt   = pos_prev;
          left_nxt  = left_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          occ_nxt    = occ_r + 1'b1;
          res_ev_nxt = EV_REGISTERED;
          state_nxt  = S_PUSH;
        end
      end

      S_TICK_RD: begin
        res_woken_nxt = '0;
        res_ev_nxt    = EV_NONE_DUE;
        state_nxt     = (occ_r == '0) ? S_PUSH : S_TICK_CMP;
      end

      // head due: pop it by advancing the ring
      S_TICK_CMP: begin
        if (mem_rd_r.due_time <= time_r) begin
          res_ev_nxt    = EV_FIRED;
          res_woken_nxt = mem_rd_r;
          head_nxt      = head_next;
          occ_nxt       = occ_r - 1'b1;
          fired_nxt     = fired_r + 1'b1;
        end
        state_nxt = S_PUSH;
      end

      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = res_ev_r;
          out_woken_nxt = res_woken_r;
          out_pend_nxt  = PendW'(occ_r);
          out_fired_nxt = fired_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    left_r      <= left_nxt;
    room_r      <= room_nxt;
    time_r      <= time_nxt;
    res_ev_r    <= res_ev_nxt;
    res_woken_r <= res_woken_nxt;
    out_ev_r    <= out_ev_nxt;
    out_woken_r <= out_woken_nxt;
    out_pend_r  <= out_pend_nxt;
    out_fired_r <= out_fired_nxt;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {3'b000, out_fired_r, out_pend_r,
                       out_woken_r.due_time, out_woken_r.room};

endmodule

// ===== hdl/saq_checker.sv =====
`timescale 1ns / 1ps

module saq_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [47:0]                in_tdata,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [87:0]                out_tdata,
  input logic [saq_pkg::EventW-1:0] out_tuser
);
  import saq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // only a fired wakeup reports a room and time
  a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_FIRED |-> out_tdata[45:0] == '0)
    else $error("woken fields set without a wakeup");

  // a drop is reported only with a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_DROPPED |-> out_tdata[52:46] == PendW'(QUEUE_DEPTH))
    else $error("drop reported below full");

endmodule

bind sorted_alarm_timer_queue saq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_saq_checker (.*);

// ===== dv/tb_sorted_alarm_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_alarm_timer_queue;
  import saq_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  // input mode carried on in_tuser
  localparam bit MODE_REGISTER = 1'b0;
  localparam bit MODE_TICK     = 1'b1;

  typedef struct {
    logic [EventW-1:0] ev;
    logic [RoomW-1:0]  room;
    logic [TimeW-1:0]  due;
    logic [PendW-1:0]  pending;
    logic [FiredW-1:0] fired;
  } alarm_reply_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // room_number[13:0], alarm_time[45:14]
  logic        in_tuser   = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;         // woken_room, woken_time, pending_count, expired_count
  logic [EventW-1:0] out_tuser;   // event_res

  // predictor state: sorted alarm slots, occupancy and wakeup total
  entry_t            alarm_slots [DEPTH];
  int                slots_used    = 0;
  logic [FiredW-1:0] wakeups_fired = '0;
  int                peak_slots    = 0;
  int                ev_seen [4]   = '{0, 0, 0, 0};

  alarm_reply_t reply_fifo [$];
  int           mismatch_count = 0;
  int           items_sent     = 0;
  int           in_idle_pct    = 35;
  int           out_idle_pct   = 35;
  int           stall_cycles   = 0;
  logic [TimeW-1:0] wall_seconds = '0;

  sorted_alarm_timer_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // result side backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 30)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // expected reply for one accepted transaction; updates the predictor state
  function automatic alarm_reply_t predict_alarm_reply(input bit mode,
      input logic [RoomW-1:0] room, input logic [TimeW-1:0] stamp);
    alarm_reply_t r;
    int pos;
    r = '{ev: EV_NONE_DUE, room: '0, due: '0, pending: '0, fired: '0};
    if (mode == MODE_REGISTER) begin
      if (slots_used >= DEPTH) begin
        r.ev = EV_DROPPED;
      end else begin
        // new alarm goes behind every entry due at or before it
        pos = 0;
        while (pos < slots_used && alarm_slots[pos].due_time <= stamp) pos++;
        for (int k = slots_used; k > pos; k--) alarm_slots[k] = alarm_slots[k-1];
        alarm_slots[pos] = '{due_time: stamp, room: room};
        slots_used++;
        r.ev = EV_REGISTERED;
      end
    end else if (slots_used > 0 && alarm_slots[0].due_time <= stamp) begin
      // head is due: pop it
      r.ev   = EV_FIRED;
      r.room = alarm_slots[0].room;
      r.due  = alarm_slots[0].due_time;
      for (int k = 0; k + 1 < slots_used; k++) alarm_slots[k] = alarm_slots[k+1];
      slots_used--;
      wakeups_fired = wakeups_fired + 1'b1;
    end
    r.pending = PendW'(slots_used);
    r.fired   = wakeups_fired;
    ev_seen[r.ev]++;
    if (slots_used > peak_slots) peak_slots = slots_used;
    return r;
  endfunction

  // offer one transaction at the falling edge, hold it until accepted
  task automatic send_alarm_item(input bit mode, input logic [RoomW-1:0] room,
      input logic [TimeW-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, stamp, room};
    do @(posedge clk); while (!in_tready);
    reply_fifo.push_back(predict_alarm_reply(mode, room, stamp));
    items_sent++;
  endtask

  task automatic park_input;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_replies
    alarm_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_fifo.size() == 0) begin
        report_mismatch("result transaction with no item outstanding");
      end else begin
        want = reply_fifo.pop_front();
        if (out_tuser !== want.ev)
          report_mismatch($sformatf("event_res got %0d want %0d", out_tuser, want.ev));
        if (out_tdata[13:0] !== want.room)
          report_mismatch($sformatf("woken_room got %0d want %0d",
                                    out_tdata[13:0], want.room));
        if (out_tdata[45:14] !== want.due)
          report_mismatch($sformatf("woken_time got %0d want %0d",
                                    out_tdata[45:14], want.due));
        if (out_tdata[52:46] !== want.pending)
          report_mismatch($sformatf("pending_count got %0d want %0d",
                                    out_tdata[52:46], want.pending));
        if (out_tdata[84:53] !== want.fired)
          report_mismatch($sformatf("expired_count got %0d want %0d",
                                    out_tdata[84:53], want.fired));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // empty queue, extreme fields, equal times, due exactly now and not yet due
  task automatic test_directed;
    send_alarm_item(MODE_TICK, 14'h0000, 32'h0000_0000);      // empty queue
    send_alarm_item(MODE_TICK, 14'h3fff, 32'hffff_ffff);      // empty queue, max time
    send_alarm_item(MODE_REGISTER, 14'h0000, 32'hffff_ffff);
    send_alarm_item(MODE_REGISTER, 14'h3fff, 32'h0000_0000);
    send_alarm_item(MODE_REGISTER, 14'h2aaa, 32'd100);
    send_alarm_item(MODE_REGISTER, 14'h1555, 32'd100);        // same time, arrival order
    send_alarm_item(MODE_REGISTER, 14'h0007, 32'd100);
    send_alarm_item(MODE_TICK, 14'h1234, 32'd0);              // head due exactly now
    send_alarm_item(MODE_TICK, 14'h0000, 32'd99);             // head not yet due
    send_alarm_item(MODE_TICK, 14'h3fff, 32'd100);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd101);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd100);
    send_alarm_item(MODE_TICK, 14'h0000, 32'hffff_fffe);      // max-time entry not due
    send_alarm_item(MODE_TICK, 14'h0000, 32'hffff_ffff);
    send_alarm_item(MODE_TICK, 14'h0000, 32'hffff_ffff);      // empty again
    send_alarm_item(MODE_REGISTER, 14'h0005, 32'd50);
    send_alarm_item(MODE_REGISTER, 14'h0006, 32'd10);         // goes in front of head
    send_alarm_item(MODE_REGISTER, 14'h0008, 32'd50);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd1000);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd1000);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd1000);
    send_alarm_item(MODE_TICK, 14'h0000, 32'd1000);
    park_input();
  endtask

  // fill to capacity, overflow, refill and drain
  task automatic test_queue_full;
    while (slots_used < DEPTH)
      send_alarm_item(MODE_REGISTER, 14'($urandom),
                      $urandom_range(1) ? 32'($urandom_range(0, 31)) : 32'($urandom));
    send_alarm_item(MODE_REGISTER, 14'h3fff, 32'h0000_0000);
    send_alarm_item(MODE_REGISTER, 14'h0000, 32'hffff_ffff);
    send_alarm_item(MODE_REGISTER, 14'($urandom), 32'($urandom));
    send_alarm_item(MODE_TICK, 14'($urandom), 32'hffff_ffff);
    send_alarm_item(MODE_REGISTER, 14'($urandom), 32'($urandom_range(0, 31)));
    send_alarm_item(MODE_REGISTER, 14'($urandom), 32'($urandom));
    while (slots_used > 0)
      send_alarm_item(MODE_TICK, 14'($urandom), 32'hffff_ffff);
    send_alarm_item(MODE_TICK, 14'($urandom), 32'($urandom));
    park_input();
  endtask

  // bursts with varying register/tick mix around a running wall clock
  task automatic test_random_traffic(input int n_items);
    int done_items;
    int burst_len;
    int reg_pct;
    logic [TimeW-1:0] due;
    done_items = 0;
    while (done_items < n_items) begin
      burst_len = $urandom_range(30, 150);
      case ($urandom_range(3))
        0:       reg_pct = 85;
        1:       reg_pct = 50;
        2:       reg_pct = 30;
        default: reg_pct = 60;
      endcase
      if ($urandom_range(9) == 0) wall_seconds = $urandom;
      // an opening stretch runs with both sides always ready
      in_idle_pct  = (done_items < 300) ? 0 : 35;
      out_idle_pct = in_idle_pct;
      for (int k = 0; k < burst_len && done_items < n_items; k++) begin
        if ($urandom_range(99) < reg_pct) begin
          case ($urandom_range(9))
            0:       due = $urandom;
            1:       due = wall_seconds;
            default: due = wall_seconds + $urandom_range(1, 400);
          endcase
          send_alarm_item(MODE_REGISTER, 14'($urandom), due);
        end else begin
          wall_seconds = wall_seconds + $urandom_range(0, 40);
          send_alarm_item(MODE_TICK, 14'($urandom),
                          ($urandom_range(19) == 0) ? 32'($urandom) : wall_seconds);
        end
        done_items++;
      end
    end
    park_input();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_queue_full();
    test_random_traffic(1590);

    wait (reply_fifo.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d registered, %0d dropped on a full queue, %0d fired, %0d idle ticks.",
             items_sent, ev_seen[EV_REGISTERED], ev_seen[EV_DROPPED], ev_seen[EV_FIRED],
             ev_seen[EV_NONE_DUE]);
    $display("Deepest queue reached: %0d of %0d entries.", peak_slots, DEPTH);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
